### design/ssis_pkg.sv
`default_nettype none
// Package for the sparse-set item store: capacities, field widths, codes and map entry type.
// Used by sparse_set_item_store; depends on nothing else.
package ssis_pkg;

   localparam int ID_SLOTS    = 1024;
   localparam int DENSE_SLOTS = 256;
   localparam int ITEM_WIDTH  = 32;

   localparam int ID_W    = $clog2(ID_SLOTS);
   localparam int SLOT_W  = $clog2(DENSE_SLOTS);
   localparam int COUNT_W = $clog2(DENSE_SLOTS + 1);

   localparam int FUNC_W       = 2;
   localparam int ENTITY_W     = 10;
   localparam int DATA_W       = 32;
   localparam int STATUS_W     = 3;
   localparam int SLOT_OUT_W   = 8;
   localparam int LIVE_TOTAL_W = 9;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_GET    = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 3'd0,
      STATUS_RANGE  = 3'd1,
      STATUS_DUP    = 3'd2,
      STATUS_ABSENT = 3'd3,
      STATUS_FULL   = 3'd4
   } status_type;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } map_entry_type;

endpackage
`default_nettype wire

### design/sparse_set_item_store.sv
`default_nettype none
// Sparse-set item store: entity id map, packed dense slots, payload memory and control.
// Depends on ssis_pkg.
//
// The store keeps up to 256 payload words packed in dense slots and finds them through a
// 1024-entry id map held in synchronous RAM. After reset the block sweeps the id map clear,
// one entry per clock, and req_stall stays high until it ends. Afterwards one request is
// worked on at a time: add, an absent get and every rejected request go from lookup
// straight to reply; a get that hits passes a fetch state and a remove that moves the last
// slot a move state, because each step waits for the synchronous read of the id map and
// then of the dense memories before writing back. A finished result sits in an output
// register, so the next request can be taken while the previous result is still stalled.
module sparse_set_item_store (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [ssis_pkg::FUNC_W-1:0]         req_func,
   input  wire  [ssis_pkg::ENTITY_W-1:0]       req_entity_id,
   input  wire  [ssis_pkg::DATA_W-1:0]         req_item_data,
   input  wire                                 req_data_given,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [ssis_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_present,
   output logic [ssis_pkg::DATA_W-1:0]         rsp_item_out,
   output logic [ssis_pkg::SLOT_OUT_W-1:0]     rsp_slot_out,
   output logic [ssis_pkg::LIVE_TOTAL_W-1:0]   rsp_live_total
);

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_LOOKUP = 6'b000100,
      S_FETCH  = 6'b001000,
      S_MOVE   = 6'b010000,
      S_REPLY  = 6'b100000
   } state_type;

   localparam int ID_W    = ssis_pkg::ID_W;
   localparam int SLOT_W  = ssis_pkg::SLOT_W;
   localparam int COUNT_W = ssis_pkg::COUNT_W;
   localparam int ITEM_W  = ssis_pkg::ITEM_WIDTH;

   ssis_pkg::map_entry_type id_map [ssis_pkg::ID_SLOTS];
   logic [ID_W-1:0]         slot_id [ssis_pkg::DENSE_SLOTS];
   logic [ITEM_W-1:0]       slot_pay [ssis_pkg::DENSE_SLOTS];

   state_type state_ff, state_in;
   logic [ID_W-1:0]    clr_ff, clr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   ssis_pkg::func_type func_ff;
   logic [ssis_pkg::ENTITY_W-1:0] id_ff;
   logic [ITEM_W-1:0]  data_ff;
   logic [SLOT_W-1:0]  hole_ff, hole_in;

   ssis_pkg::status_type res_status_ff, res_status_in;
   logic                 res_present_ff, res_present_in;
   logic [ssis_pkg::DATA_W-1:0]     res_item_ff, res_item_in;
   logic [ssis_pkg::SLOT_OUT_W-1:0] res_slot_ff, res_slot_in;

   logic rsp_valid_ff, rsp_valid_in;
   ssis_pkg::status_type rsp_status_ff;
   logic                 rsp_present_ff;
   logic [ssis_pkg::DATA_W-1:0]       rsp_item_ff;
   logic [ssis_pkg::SLOT_OUT_W-1:0]   rsp_slot_ff;
   logic [ssis_pkg::LIVE_TOTAL_W-1:0] rsp_total_ff;

   ssis_pkg::map_entry_type map_rd_ff, map_wdata;
   logic [ID_W-1:0]   map_waddr, moved_id;
   logic              map_we, map_re;
   logic [ITEM_W-1:0] pay_rd_ff;
   logic [ID_W-1:0]   sid_rd_ff;
   logic              dense_we, dense_re;
   logic [SLOT_W-1:0] dense_waddr, dense_raddr, last_slot;
   logic [ID_W-1:0]   sid_wdata;
   logic [ITEM_W-1:0] pay_wdata;

   logic req_xfer, load_rsp, in_range;

   assign req_xfer  = req_valid && !req_stall;
   assign load_rsp  = (state_ff == S_REPLY) && (!rsp_valid_ff || !rsp_stall);
   assign in_range  = 32'(id_ff) < ssis_pkg::ID_SLOTS;
   assign last_slot = SLOT_W'(count_ff - COUNT_W'(1));
   assign moved_id  = sid_rd_ff;
   assign map_re    = req_xfer;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      count_in       = count_ff;
      hole_in        = hole_ff;
      res_status_in  = res_status_ff;
      res_present_in = res_present_ff;
      res_item_in    = res_item_ff;
      res_slot_in    = res_slot_ff;
      req_stall      = 1'b1;
      map_we         = 1'b0;
      map_waddr      = ID_W'(id_ff);
      map_wdata      = '0;
      dense_we       = 1'b0;
      dense_waddr    = count_ff[SLOT_W-1:0];
      sid_wdata      = ID_W'(id_ff);
      pay_wdata      = data_ff;
      dense_re       = 1'b0;
      dense_raddr    = last_slot;
      unique case (state_ff)
         S_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            clr_in    = clr_ff + ID_W'(1);
            if (clr_ff == ID_W'(ssis_pkg::ID_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            res_status_in  = ssis_pkg::STATUS_OK;
            res_present_in = 1'b0;
            res_item_in    = '0;
            res_slot_in    = '0;
            state_in       = S_REPLY;
            priority if (func_ff == ssis_pkg::FUNC_NONE) begin
               res_status_in = ssis_pkg::STATUS_OK;
            end else if (!in_range) begin
               res_status_in = ssis_pkg::STATUS_RANGE;
            end else if (func_ff == ssis_pkg::FUNC_ADD) begin
               if (map_rd_ff.valid) begin
                  res_status_in  = ssis_pkg::STATUS_DUP;
                  res_present_in = 1'b1;
                  res_slot_in    = ssis_pkg::SLOT_OUT_W'(map_rd_ff.slot);
               end else if (count_ff >= COUNT_W'(ssis_pkg::DENSE_SLOTS)) begin
                  res_status_in = ssis_pkg::STATUS_FULL;
               end else begin
                  dense_we       = 1'b1;
                  map_we         = 1'b1;
                  map_wdata      = '{valid: 1'b1, slot: count_ff[SLOT_W-1:0]};
                  count_in       = count_ff + COUNT_W'(1);
                  res_present_in = 1'b1;
                  res_slot_in    = ssis_pkg::SLOT_OUT_W'(count_ff[SLOT_W-1:0]);
               end
            end else if (func_ff == ssis_pkg::FUNC_REMOVE) begin
               if (!map_rd_ff.valid || count_ff == '0) begin
                  res_status_in = ssis_pkg::STATUS_ABSENT;
               end else begin
                  map_we   = 1'b1;
                  count_in = count_ff - COUNT_W'(1);
                  hole_in  = map_rd_ff.slot;
                  if (map_rd_ff.slot != last_slot) begin
                     dense_re = 1'b1;
                     state_in = S_MOVE;
                  end
               end
            end else begin
               if (!map_rd_ff.valid) begin
                  res_status_in = ssis_pkg::STATUS_ABSENT;
               end else begin
                  dense_re    = 1'b1;
                  dense_raddr = map_rd_ff.slot;
                  hole_in     = map_rd_ff.slot;
                  state_in    = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            res_present_in = 1'b1;
            res_item_in    = ssis_pkg::DATA_W'(pay_rd_ff);
            res_slot_in    = ssis_pkg::SLOT_OUT_W'(hole_ff);
            state_in       = S_REPLY;
         end
         S_MOVE: begin
            dense_we    = 1'b1;
            dense_waddr = hole_ff;
            sid_wdata   = sid_rd_ff;
            pay_wdata   = pay_rd_ff;
            map_we      = 1'b1;
            map_waddr   = moved_id;
            map_wdata   = '{valid: 1'b1, slot: hole_ff};
            state_in    = S_REPLY;
         end
         S_REPLY: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff <= ssis_pkg::func_type'(req_func);
         id_ff   <= req_entity_id;
         data_ff <= req_data_given ? ITEM_W'(req_item_data) : '0;
      end
      hole_ff        <= hole_in;
      res_status_ff  <= res_status_in;
      res_present_ff <= res_present_in;
      res_item_ff    <= res_item_in;
      res_slot_ff    <= res_slot_in;
      if (load_rsp) begin
         rsp_status_ff  <= res_status_ff;
         rsp_present_ff <= res_present_ff;
         rsp_item_ff    <= res_item_ff;
         rsp_slot_ff    <= res_slot_ff;
         rsp_total_ff   <= ssis_pkg::LIVE_TOTAL_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         id_map[map_waddr] <= map_wdata;
      end
      if (map_re) begin
         map_rd_ff <= id_map[ID_W'(req_entity_id)];
      end
   end

   always_ff @(posedge clock) begin
      if (dense_we) begin
         slot_id[dense_waddr] <= sid_wdata;
      end
      if (dense_re) begin
         sid_rd_ff <= slot_id[dense_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (dense_we) begin
         slot_pay[dense_waddr] <= pay_wdata;
      end
      if (dense_re) begin
         pay_rd_ff <= slot_pay[dense_raddr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_item_out   = rsp_item_ff;
   assign rsp_slot_out   = rsp_slot_ff;
   assign rsp_live_total = rsp_total_ff;

`ifndef NO_ASSERTIONS
   // The live count can never pass the dense capacity.
   count_bound_a: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(ssis_pkg::DENSE_SLOTS))
      else $error("live count exceeds dense capacity");

   // An accepted request always moves straight to the map lookup.
   accept_lookup_a: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_LOOKUP))
      else $error("accepted request did not enter lookup");

   // A finished result waits while the output register is still held.
   reply_hold_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY && rsp_valid_ff && rsp_stall) |=> (state_ff == S_REPLY))
      else $error("result dropped while output stalled");

   // Only an add that succeeds raises the live count.
   count_grow_a: assert property (@(posedge clock) disable iff (reset)
      (count_in > count_ff) |-> (state_ff == S_LOOKUP && func_ff == ssis_pkg::FUNC_ADD))
      else $error("live count grew outside an add");
`endif

endmodule
`default_nettype wire

### bench/ssis_store_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the sparse-set item store: a predictor of the id map, dense slots and count,
// and a queue of expected responses. Depends on ssis_pkg.
package ssis_store_check_pkg;
   import ssis_pkg::*;

   typedef struct packed {
      status_type                status;
      logic                      present;
      logic [DATA_W-1:0]         item;
      logic [SLOT_OUT_W-1:0]     slot;
      logic [LIVE_TOTAL_W-1:0]   live;
   } store_rsp_type;

   class store_scoreboard;
      bit                  id_valid [ID_SLOTS];
      bit [SLOT_W-1:0]     id_slot [ID_SLOTS];
      bit [ID_W-1:0]       slot_owner [DENSE_SLOTS];
      bit [ITEM_WIDTH-1:0] slot_word [DENSE_SLOTS];
      int unsigned         live_count;
      store_rsp_type       expected_rsp_q [$];
      int unsigned         mismatches;

      function new();
         live_count = 0;
         mismatches = 0;
      endfunction

      function store_rsp_type predict_store(func_type f, bit [ID_W-1:0] id,
                                            bit [DATA_W-1:0] data, bit given);
         store_rsp_type r;
         int unsigned   hole;
         int unsigned   last;
         bit [ID_W-1:0] moved;
         r = '0;
         r.status = STATUS_OK;
         if (f == FUNC_NONE) begin
         end else if (int'(id) >= ID_SLOTS) begin
            r.status = STATUS_RANGE;
         end else begin
            case (f)
               FUNC_ADD: begin
                  if (id_valid[id]) begin
                     r.status = STATUS_DUP;
                     r.present = 1'b1;
                     r.slot = id_slot[id];
                  end else if (live_count >= DENSE_SLOTS) begin
                     r.status = STATUS_FULL;
                  end else begin
                     r.slot = live_count[SLOT_OUT_W-1:0];
                     slot_word[live_count] = given ? data : '0;
                     slot_owner[live_count] = id;
                     id_slot[id] = live_count[SLOT_W-1:0];
                     id_valid[id] = 1'b1;
                     live_count++;
                     r.present = 1'b1;
                  end
               end
               FUNC_REMOVE: begin
                  if (!id_valid[id] || live_count == 0) begin
                     r.status = STATUS_ABSENT;
                  end else begin
                     hole = 32'(id_slot[id]);
                     last = live_count - 1;
                     if (hole != last) begin
                        moved = slot_owner[last];
                        slot_word[hole] = slot_word[last];
                        slot_owner[hole] = moved;
                        id_slot[moved] = hole[SLOT_W-1:0];
                     end
                     id_valid[id] = 1'b0;
                     id_slot[id] = '0;
                     live_count = last;
                  end
               end
               default: begin
                  if (!id_valid[id]) begin
                     r.status = STATUS_ABSENT;
                  end else begin
                     r.slot = id_slot[id];
                     r.present = 1'b1;
                     r.item = slot_word[id_slot[id]];
                  end
               end
            endcase
         end
         r.live = live_count[LIVE_TOTAL_W-1:0];
         return r;
      endfunction

      function void note_request(func_type f, bit [ID_W-1:0] id, bit [DATA_W-1:0] data,
                                 bit given);
         expected_rsp_q.push_back(predict_store(f, id, data, given));
      endfunction

      function void check_response(store_rsp_type got);
         store_rsp_type want;
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response transfer with nothing expected", $time);
            return;
         end
         want = expected_rsp_q.pop_front();
         if (got.status !== want.status || got.present !== want.present ||
             got.item !== want.item || got.slot !== want.slot || got.live !== want.live) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: expected st %0d pr %0d item %h slot %0d live %0d, ",
                         "got st %0d pr %0d item %h slot %0d live %0d"},
                        $time, want.status, want.present, want.item, want.slot, want.live,
                        got.status, got.present, got.item, got.slot, got.live);
         end
      endfunction

      function bit [ID_W-1:0] choose_entity(int unsigned live_pct);
         if (live_count > 0 && $urandom_range(0, 99) < live_pct)
            return slot_owner[$urandom_range(0, live_count - 1)];
         return ID_W'($urandom_range(0, ID_SLOTS - 1));
      endfunction
   endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for sparse_set_item_store: clock, reset, request and response drivers.
// Depends on ssis_pkg, ssis_store_check_pkg and the store RTL.
module tb_top;
   import ssis_pkg::*;
   import ssis_store_check_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int FILL_ITEMS   = 340;
   localparam int QUIET_ITEMS  = 60;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [FUNC_W-1:0]       req_func;
   logic [ENTITY_W-1:0]     req_entity_id;
   logic [DATA_W-1:0]       req_item_data;
   logic                    req_data_given;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_present;
   logic [DATA_W-1:0]       rsp_item_out;
   logic [SLOT_OUT_W-1:0]   rsp_slot_out;
   logic [LIVE_TOTAL_W-1:0] rsp_live_total;

   logic                    idle_on;
   store_scoreboard         board;

   sparse_set_item_store u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_entity_id  (req_entity_id),
      .req_item_data  (req_item_data),
      .req_data_given (req_data_given),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_present    (rsp_present),
      .rsp_item_out   (rsp_item_out),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_live_total (rsp_live_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("sparse_set_item_store verification failed");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(0, 5)) @(negedge clock);
            @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response('{status_type'(rsp_status), rsp_present, rsp_item_out,
                                rsp_slot_out, rsp_live_total});
   end

   task automatic send_request(func_type f, logic [ENTITY_W-1:0] id, logic [DATA_W-1:0] data,
                               logic given);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_func = f;
      req_entity_id = id;
      req_item_data = data;
      req_data_given = given;
      do @(posedge clock); while (req_stall);
      board.note_request(f, id, data, given);
      @(negedge clock);
   endtask

   task automatic random_request(int unsigned add_pct, int unsigned remove_pct,
                                 int unsigned get_pct);
      int unsigned pick;
      func_type    f;
      pick = $urandom_range(0, 99);
      if (pick < add_pct)
         f = FUNC_ADD;
      else if (pick < add_pct + remove_pct)
         f = FUNC_REMOVE;
      else if (pick < add_pct + remove_pct + get_pct)
         f = FUNC_GET;
      else
         f = FUNC_NONE;
      send_request(f, board.choose_entity(f == FUNC_ADD ? 15 : 75), $urandom,
                   $urandom_range(0, 9) != 0);
   endtask

   initial begin
      bit calm;
      board = new();
      idle_on = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_NONE;
      req_entity_id = '0;
      req_item_data = '0;
      req_data_given = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      idle_on = 1'b1;

      send_request(FUNC_GET,    10'd0,    32'h0,        1'b0);
      send_request(FUNC_REMOVE, 10'd0,    32'h0,        1'b0);
      send_request(FUNC_ADD,    10'd0,    32'hFFFF_FFFF, 1'b1);
      send_request(FUNC_ADD,    10'd1023, 32'h0,        1'b1);
      send_request(FUNC_ADD,    10'd512,  32'hA5A5_5A5A, 1'b0);
      send_request(FUNC_ADD,    10'd0,    32'h1234_0000, 1'b1);
      send_request(FUNC_GET,    10'd0,    32'h0,        1'b0);
      send_request(FUNC_GET,    10'd1023, 32'hFFFF_FFFF, 1'b1);
      send_request(FUNC_GET,    10'd512,  32'h0,        1'b0);
      send_request(FUNC_NONE,   10'd1023, 32'hFFFF_FFFF, 1'b1);
      send_request(FUNC_REMOVE, 10'd0,    32'h0,        1'b0);
      send_request(FUNC_GET,    10'd512,  32'h0,        1'b0);
      send_request(FUNC_GET,    10'd0,    32'h0,        1'b0);
      send_request(FUNC_REMOVE, 10'd0,    32'h0,        1'b0);
      send_request(FUNC_REMOVE, 10'd1023, 32'h0,        1'b0);
      send_request(FUNC_REMOVE, 10'd512,  32'h0,        1'b0);
      send_request(FUNC_ADD,    10'd5,    32'h1234_5678, 1'b1);
      send_request(FUNC_ADD,    10'd6,    32'h8000_0001, 1'b1);
      send_request(FUNC_GET,    10'd6,    32'h0,        1'b0);
      send_request(FUNC_REMOVE, 10'd5,    32'h0,        1'b0);
      send_request(FUNC_GET,    10'd6,    32'h0,        1'b0);

      calm = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 32 == 0)
            calm = ($urandom_range(0, 3) == 0);
         idle_on = !calm && (i < RANDOM_ITEMS - QUIET_ITEMS);
         if (i < FILL_ITEMS)
            random_request(86, 5, 6);
         else
            random_request(25, 40, 30);
      end

      req_valid = 1'b0;
      idle_on = 1'b0;
      while (board.expected_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.expected_rsp_q.size() == 0)
         $display("sparse_set_item_store verification clean");
      else
         $display("sparse_set_item_store verification failed");
      $finish;
   end

endmodule

### files.f
design/ssis_pkg.sv
design/sparse_set_item_store.sv
bench/ssis_store_check_pkg.sv
bench/tb_top.sv
